// File: rtl/bdema_pkg.sv
// Shared constants and types for the band dead-zone moving-average block.
package bdema_pkg;

    // Item field widths.
    localparam int BAND_W   = 3;
    localparam int SAMPLE_W = 10;
    localparam int LEVEL_W  = 10;
    localparam int AVG_W    = 18;
    localparam int FACTOR_W = 16;
    localparam int DZ_W     = 10;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_ZONE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTHING = 1'd1;

    // Register reset values.
    localparam logic [DZ_W-1:0]     DEAD_ZONE_RST = '0;
    localparam logic [FACTOR_W-1:0] SMOOTHING_RST = 16'd32768;

    // Parameter defaults.
    localparam int BANDS_DEF   = 7;
    localparam int ADC_MAX_DEF = 1023;

    // Largest value the level field holds.
    localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/bdema_div.sv
// Restoring divider that retires one quotient bit per cycle.
module bdema_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUM_W-1:0]       num,
    input  logic [DEN_W-1:0]       den,
    output bdema_pkg::div_stat_t   stat,
    output logic [NUM_W-1:0]       quo
);
    import bdema_pkg::*;

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] shift_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    // One trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial = {rem_reg, shift_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    // Control state: busy while bits remain, done pulses once at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out while quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= num;
            den_reg   <= den;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[NUM_W-2:0], fits};
            rem_reg   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = shift_reg;

endmodule

// File: rtl/band_deadzone_ema_core.sv
// Top level: dead-zone removal, rescaling and per-band moving average.
//
//  Channel   Dir  Handshake              Payload
//  s_axis    in   s_tvalid / s_tready    s_tdata: band[2:0], sample[12:3]
//  m_axis    out  m_tvalid / m_tready    m_tdata: band_out[2:0], level[12:3],
//                                                 average[30:13]
//  cfg       in   cfg_we (no wait)       cfg_addr, cfg_data
//
// Each item passes through S_PREP, S_DIV (the bit-serial divider that
// rescales the reading), S_MUL and S_DONE; the next item is taken only
// after the last one retires to the output register.
// Averages sit in a small synchronous memory; per-band valid bits cleared
// by reset make unwritten bands read as zero, so no clearing pass is needed.
// A finished result waits in the output register; the next item is taken
// while it waits, and only the final write-back stalls on a full output.
module band_deadzone_ema_core #(
    parameter int BANDS   = bdema_pkg::BANDS_DEF,
    parameter int ADC_MAX = bdema_pkg::ADC_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // band[2:0], sample[12:3], zeros above
    input  logic [bdema_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // band_out[2:0], level[12:3], average[30:13], zero at bit 31
    output logic [bdema_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic [bdema_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bdema_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bdema_pkg::*;

    localparam int ADC_W   = $clog2(ADC_MAX + 1);
    localparam int NUM_W   = SAMPLE_W + ADC_W;
    localparam int IDX_W   = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int EXT_W   = (IDX_W > BAND_W) ? IDX_W : BAND_W;
    localparam int LVL_CAP = (ADC_MAX < LEVEL_MAX) ? ADC_MAX : LEVEL_MAX;
    localparam int PROD_W  = FACTOR_W + 1 + AVG_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [DZ_W-1:0]      dz_reg;
    logic [FACTOR_W-1:0]  f_reg;
    logic [BAND_W-1:0]    band_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [AVG_W-1:0]     rd_reg;
    logic [LEVEL_W-1:0]   lvl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;
    logic [BANDS-1:0]     valid_reg;
    logic [AVG_W-1:0]     mem [BANDS];

    logic [BAND_W-1:0]    in_band;
    logic [SAMPLE_W-1:0]  in_sample;
    logic [EXT_W-1:0]     in_band_ext;
    logic [IDX_W-1:0]     in_idx;
    logic [EXT_W-1:0]     band_ext;
    logic [IDX_W-1:0]     idx;
    logic                 in_range;
    logic                 accept;
    logic                 is_zero;
    logic                 is_full;
    logic [SAMPLE_W-1:0]  sdiff;
    logic [NUM_W-1:0]     div_num;
    logic [ADC_W-1:0]     div_den;
    logic                 div_start;
    div_stat_t            div_stat;
    logic [NUM_W-1:0]     div_quo;
    logic [LEVEL_W-1:0]   lvl_now;
    logic [AVG_W-1:0]     avg_old;
    logic signed [AVG_W:0] delta;
    logic [AVG_W+1:0]     avg_sum;
    logic [AVG_W-1:0]     avg_new;
    logic                 finish;

    // Field unpacking and band index decode.
    always_comb
    begin
        in_band     = s_tdata[BAND_W-1:0];
        in_sample   = s_tdata[BAND_W +: SAMPLE_W];
        in_band_ext = EXT_W'(in_band);
        in_idx      = in_band_ext[IDX_W-1:0];
        band_ext    = EXT_W'(band_reg);
        idx         = band_ext[IDX_W-1:0];
        in_range    = (32'(band_reg) < BANDS);
        accept      = s_tvalid && s_tready;
    end

    // Rescale setup: silence test, degenerate span test, dividend and divisor.
    always_comb
    begin
        is_zero   = (sample_reg <= dz_reg);
        is_full   = (32'(dz_reg) >= ADC_MAX);
        sdiff     = sample_reg - dz_reg;
        div_num   = NUM_W'(sdiff) * NUM_W'(ADC_MAX);
        div_den   = is_full ? ADC_W'(1) : ADC_W'(ADC_MAX - 32'(dz_reg));
        div_start = (state_reg == S_PREP);
    end

    bdema_div #(
        .NUM_W (NUM_W),
        .DEN_W (ADC_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Level selection and the moving-average update.
    always_comb
    begin
        if (is_zero)
            lvl_now = '0;
        else if (is_full || (div_quo > NUM_W'(LVL_CAP)))
            lvl_now = LEVEL_W'(LVL_CAP);
        else
            lvl_now = div_quo[LEVEL_W-1:0];
        avg_old = (in_range && valid_reg[idx]) ? rd_reg : '0;
        delta   = $signed({1'b0, lvl_now, 8'd0}) - $signed({1'b0, avg_old});
        avg_sum = {2'b00, avg_old} + prod_reg[PROD_W-3:FACTOR_W];
        avg_new = avg_sum[AVG_W-1:0];
        finish  = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg <= DEAD_ZONE_RST;
            f_reg  <= SMOOTHING_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DEAD_ZONE: dz_reg <= cfg_data[DZ_W-1:0];
                REG_SMOOTHING: f_reg  <= cfg_data[FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer with the registered output item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (finish)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_stat.done)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (finish)
                    begin
                        if (in_range)
                            valid_reg[idx] <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            band_reg   <= in_band;
            sample_reg <= in_sample;
        end
        if (state_reg == S_MUL)
        begin
            lvl_reg  <= lvl_now;
            prod_reg <= $signed({1'b0, f_reg}) * delta;
        end
        if (finish)
            out_data_reg <= M_DATA_W'({avg_sum[AVG_W-1:0] & {AVG_W{in_range}},
                                       lvl_reg, band_reg});
    end

    // Average store: read at acceptance, written back when the item retires.
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= mem[in_idx];
        if (finish && in_range)
            mem[idx] <= avg_new;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The divider only runs while an item is in flight.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_stat.busy)
        else $error("divider busy while block is idle");

    // After an item is taken no second item enters until it retires.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // The divider finishes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider result arrived outside the divide phase");

endmodule
